// File: rtl/core/fme_pkg.sv
// ----------------------------------------------------------------------------
// Fuzzy membership evaluator package
// Shared types, codes and constants for the membership pipeline.
// ----------------------------------------------------------------------------
package fme_pkg;

	// Q1.15 unity and fraction width of the membership result
	localparam int          FRAC_BITS = 15;
	localparam logic [15:0] ONE       = 16'd32768;

	// Clamp limits for the steepness and power registers
	localparam logic [7:0] STEEP_MIN = 8'd16;
	localparam logic [2:0] POWER_MIN = 3'd1;
	localparam logic [2:0] POWER_MAX = 3'd4;

	typedef enum logic [2:0] {
		REG_ZERO      = 3'd0,
		REG_RISING    = 3'd1,
		REG_CORE      = 3'd2,
		REG_FALLING   = 3'd3,
		REG_LSHOULDER = 3'd4,
		REG_RSHOULDER = 3'd5
	} region_t;

	typedef enum logic [2:0] {
		CFG_POINT_A   = 3'd0,
		CFG_POINT_B   = 3'd1,
		CFG_POINT_C   = 3'd2,
		CFG_POINT_D   = 3'd3,
		CFG_WIDEN     = 3'd4,
		CFG_STEEPNESS = 3'd5,
		CFG_POWER     = 3'd6
	} cfg_idx_t;

	// How the edge base is formed once the ramp has been classified
	typedef enum logic [1:0] {
		KIND_FULL = 2'd0,
		KIND_ZERO = 2'd1,
		KIND_DIV  = 2'd2
	} kind_t;

	typedef struct packed {
		region_t region;
		kind_t   kind;
	} tag_t;

endpackage

// File: rtl/core/fme_if.sv
// ----------------------------------------------------------------------------
// Fuzzy membership evaluator channels
// Sample and result streams with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fme_sample_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] crisp_value;

	modport source (output valid, output crisp_value, input ready);
	modport sink (input valid, input crisp_value, output ready);
endinterface

interface fme_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] membership;
	logic [2:0]  region;

	modport source (output valid, output membership, output region, input ready);
	modport sink (input valid, input membership, input region, output ready);
endinterface

// File: rtl/core/fuzzy_membership_eval.sv
// ----------------------------------------------------------------------------
// Fuzzy membership evaluator
// Trapezoidal membership degree with widened core, edge steepness and an
// integer edge power, evaluated by a fully pipelined datapath.
// ----------------------------------------------------------------------------
//
//   channel   role    payload                         handshake
//   -------   -----   -----------------------------   ---------------
//   sample    sink    crisp_value  (DATA_WIDTH, s)    valid / ready
//   result    source  membership (16, u), region (3)  valid / ready
//   cfg       write   cfg_idx (3), cfg_wdata (DATA_WIDTH) cfg_we, no wait
//
// One item enters per cycle while the pipeline advances; each item passes
// through five arithmetic stages, fifteen divider stages (one quotient
// bit each) and three power stages, the last being the output register.
// The whole pipeline advances together whenever the output register is
// empty or being taken; a held result freezes every stage, so nothing is
// lost or repeated. Reset clears the valid bits and loads the register
// reset values; no clearing pass is needed.
//
module fuzzy_membership_eval #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fme_sample_if.sink            sample,
	fme_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_idx,
	input  logic [DATA_WIDTH-1:0] cfg_wdata
);

	localparam int XW = DATA_WIDTH + 1;   // point differences
	localparam int NW = DATA_WIDTH + 10;  // scaled core-boundary numerators
	localparam int CW = DATA_WIDTH + 11;  // edge-extent compares
	localparam int DW = DATA_WIDTH + 15;  // edge denominators
	localparam int QW = DATA_WIDTH + 19;  // steepness-scaled numerators

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [DATA_WIDTH-1:0] a_q, b_q, c_q, d_q;
	logic [7:0]                   widen_q;
	logic [7:0]                   steep_q;
	logic [2:0]                   power_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
			widen_q <= 8'd0;
			steep_q <= fme_pkg::STEEP_MIN;
			power_q <= fme_pkg::POWER_MIN;
		end else if (cfg_we) begin
			case (cfg_idx)
				fme_pkg::CFG_POINT_A:   a_q     <= cfg_wdata;
				fme_pkg::CFG_POINT_B:   b_q     <= cfg_wdata;
				fme_pkg::CFG_POINT_C:   c_q     <= cfg_wdata;
				fme_pkg::CFG_POINT_D:   d_q     <= cfg_wdata;
				fme_pkg::CFG_WIDEN:     widen_q <= cfg_wdata[7:0];
				fme_pkg::CFG_STEEPNESS: steep_q <= cfg_wdata[7:0];
				fme_pkg::CFG_POWER:     power_q <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// Clamp steepness to at least 1.0 and the power to 1..4
	logic [7:0] steep_eff;
	logic [2:0] power_eff;

	always_comb begin
		steep_eff = (steep_q < fme_pkg::STEEP_MIN) ? fme_pkg::STEEP_MIN : steep_q;
		if (power_q < fme_pkg::POWER_MIN) begin
			power_eff = fme_pkg::POWER_MIN;
		end else if (power_q > fme_pkg::POWER_MAX) begin
			power_eff = fme_pkg::POWER_MAX;
		end else begin
			power_eff = power_q;
		end
	end

	logic signed [8:0] sf;       // steepness as a signed operand
	logic signed [8:0] wf;       // widen fraction as a signed operand
	logic signed [9:0] wl, wr;   // 256 - w and 256 + w

	assign sf = signed'({1'b0, steep_eff});
	assign wf = signed'({1'b0, widen_q});
	assign wl = 10'sd256 - signed'({2'b0, widen_q});
	assign wr = 10'sd256 + signed'({2'b0, widen_q});

	// Shoulder conditions depend only on the corner points
	logic lshoulder_ok, rshoulder_ok;

	assign lshoulder_ok = (a_q == b_q) && (b_q != c_q) && (c_q != d_q);
	assign rshoulder_ok = (c_q == d_q) && (c_q != b_q) && (b_q != a_q);

	// The whole pipeline moves when the output register can be refilled
	logic en;
	logic v_p3;

	assign en           = !v_p3 || result.ready;
	assign sample.ready = en;

	// ------------------------------------------------------------------
	// Stage 1: differences and foot compares
	// ------------------------------------------------------------------
	logic                 v_s1;
	logic signed [XW-1:0] xb_s1, xc_s1, ba_s1, dc_s1;
	logic                 lt_a_s1, gt_d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xb_s1   <= XW'(sample.crisp_value) - XW'(b_q);
			xc_s1   <= XW'(sample.crisp_value) - XW'(c_q);
			ba_s1   <= XW'(b_q) - XW'(a_q);
			dc_s1   <= XW'(d_q) - XW'(c_q);
			lt_a_s1 <= sample.crisp_value < a_q;
			gt_d_s1 <= sample.crisp_value > d_q;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: core boundary numerators, edge extents, denominators
	// ------------------------------------------------------------------
	logic                 v_s2;
	logic signed [NW-1:0] num_l_s2, num_r_s2;
	logic signed [DW-1:0] den_l_s2, den_r_s2;
	logic                 rise_ok_s2, fall_ok_s2;
	logic                 lt_a_s2, gt_d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// 256*(x - core left) and 256*(core right - x)
			num_l_s2   <= (NW'(xb_s1) <<< 8) + NW'(ba_s1) * NW'(wf);
			num_r_s2   <= NW'(dc_s1) * NW'(wf) - (NW'(xc_s1) <<< 8);
			// the rising edge starts at b - ba/n1, the falling one ends at c + dc/n1
			rise_ok_s2 <= CW'(xb_s1) * CW'(sf) >= -(CW'(ba_s1) <<< 4);
			fall_ok_s2 <= CW'(xc_s1) * CW'(sf) < (CW'(dc_s1) <<< 4);
			den_l_s2   <= (DW'(ba_s1) * DW'(wl)) <<< 4;
			den_r_s2   <= (DW'(dc_s1) * DW'(wr)) <<< 4;
			lt_a_s2    <= lt_a_s1;
			gt_d_s2    <= gt_d_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: region decision and steepness scaling of the numerator
	// ------------------------------------------------------------------
	logic                 v_s3;
	fme_pkg::region_t     region_s3;
	logic                 edge_s3;
	logic signed [QW-1:0] q_s3;
	logic signed [DW-1:0] den_s3;

	fme_pkg::region_t     region_d3;
	logic                 rising_d3;

	always_comb begin
		rising_d3 = 1'b0;
		region_d3 = fme_pkg::REG_ZERO;
		if (lt_a_s2) begin
			if (lshoulder_ok) begin
				region_d3 = fme_pkg::REG_LSHOULDER;
			end
		end else if (rise_ok_s2 && num_l_s2 < 0) begin
			region_d3 = fme_pkg::REG_RISING;
			rising_d3 = 1'b1;
		end else if (num_l_s2 >= 0 && num_r_s2 > 0) begin
			region_d3 = fme_pkg::REG_CORE;
		end else if (num_r_s2 <= 0 && fall_ok_s2) begin
			region_d3 = fme_pkg::REG_FALLING;
		end else if (gt_d_s2) begin
			if (rshoulder_ok) begin
				region_d3 = fme_pkg::REG_RSHOULDER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			region_s3 <= region_d3;
			edge_s3   <= (region_d3 == fme_pkg::REG_RISING) ||
			             (region_d3 == fme_pkg::REG_FALLING);
			q_s3      <= QW'(rising_d3 ? num_l_s2 : num_r_s2) * QW'(sf);
			den_s3    <= rising_d3 ? den_l_s2 : den_r_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: sign normalisation of the ramp fraction
	// ------------------------------------------------------------------
	logic             v_s4;
	fme_pkg::region_t region_s4;
	fme_pkg::kind_t   kind_s4;
	logic [QW-1:0]    mag_s4;
	logic [DW-1:0]    den_s4;

	logic signed [QW-1:0] qn_d4;
	logic signed [DW-1:0] dn_d4;
	fme_pkg::kind_t       kind_d4;

	always_comb begin
		qn_d4 = (den_s3 < 0) ? -q_s3 : q_s3;
		dn_d4 = (den_s3 < 0) ? -den_s3 : den_s3;
		if (!edge_s3) begin
			kind_d4 = (region_s3 == fme_pkg::REG_ZERO) ? fme_pkg::KIND_ZERO
			                                           : fme_pkg::KIND_FULL;
		end else if (den_s3 == 0 || qn_d4 >= 0) begin
			kind_d4 = fme_pkg::KIND_FULL;
		end else begin
			kind_d4 = fme_pkg::KIND_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			region_s4 <= region_s3;
			kind_s4   <= kind_d4;
			mag_s4    <= unsigned'(-qn_d4);
			den_s4    <= unsigned'(dn_d4);
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: clamp of the ramp at zero, divider operands
	// ------------------------------------------------------------------
	logic          v_s5;
	fme_pkg::tag_t tag_s5;
	logic [DW-1:0] num_s5;
	logic [DW-1:0] den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s5.region <= region_s4;
			if (kind_s4 == fme_pkg::KIND_DIV && mag_s4 >= QW'(den_s4)) begin
				tag_s5.kind <= fme_pkg::KIND_ZERO;
			end else begin
				tag_s5.kind <= kind_s4;
			end
			num_s5 <= mag_s4[DW-1:0];
			den_s5 <= den_s4;
		end
	end

	// ------------------------------------------------------------------
	// Divider: floor(32768 * mag / den), mag below den
	// ------------------------------------------------------------------
	logic                          v_dv;
	logic [fme_pkg::FRAC_BITS-1:0] quot_dv;
	fme_pkg::tag_t                 tag_dv;

	fme_div #(
		.DW (DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_num    (num_s5),
		.in_den    (den_s5),
		.in_tag    (tag_s5),
		.out_valid (v_dv),
		.out_quot  (quot_dv),
		.out_tag   (tag_dv)
	);

	// ------------------------------------------------------------------
	// Power stages: form the base, then multiply in up to three times
	// ------------------------------------------------------------------
	logic             v_p1, v_p2;
	logic [15:0]      base_p1, base_p2;
	logic [15:0]      pow_p1, pow_p2, pow_p3;
	fme_pkg::region_t region_p1, region_p2, region_p3;

	logic [15:0] base_d;
	logic [31:0] sq_d, cube_d, quad_d;

	always_comb begin
		case (tag_dv.kind)
			fme_pkg::KIND_FULL: base_d = fme_pkg::ONE;
			fme_pkg::KIND_DIV:  base_d = fme_pkg::ONE - {1'b0, quot_dv};
			default:            base_d = 16'd0;
		endcase
	end

	assign sq_d   = base_d * base_d;
	assign cube_d = pow_p1 * base_p1;
	assign quad_d = pow_p2 * base_p2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
		end else if (en) begin
			v_p1 <= v_dv;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_p1   <= base_d;
			pow_p1    <= (power_eff >= 3'd2) ? sq_d[30:15] : base_d;
			region_p1 <= tag_dv.region;

			base_p2   <= base_p1;
			pow_p2    <= (power_eff >= 3'd3) ? cube_d[30:15] : pow_p1;
			region_p2 <= region_p1;

			pow_p3    <= (power_eff >= 3'd4) ? quad_d[30:15] : pow_p2;
			region_p3 <= region_p2;
		end
	end

	assign result.valid      = v_p3;
	assign result.membership = pow_p3;
	assign result.region     = region_p3;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_full_regions: assert property (@(posedge clk) disable iff (!arst_n)
		v_p3 && (region_p3 == fme_pkg::REG_CORE || region_p3 == fme_pkg::REG_LSHOULDER ||
		         region_p3 == fme_pkg::REG_RSHOULDER) |-> pow_p3 == fme_pkg::ONE)
		else $error("full-membership region without unity degree");

	a_zero_region: assert property (@(posedge clk) disable iff (!arst_n)
		v_p3 && region_p3 == fme_pkg::REG_ZERO |-> pow_p3 == 16'd0)
		else $error("zero region with non-zero degree");

	a_degree_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_p3 |-> pow_p3 <= fme_pkg::ONE)
		else $error("membership degree above unity");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_p3 && !result.ready |=> v_p3 && $stable(pow_p3) && $stable(region_p3))
		else $error("output item changed while stalled");

endmodule

// File: rtl/core/fme_div.sv
// ----------------------------------------------------------------------------
// Fuzzy membership evaluator divider
// Restoring fractional divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module fme_div #(
	parameter int DW = 31
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [DW-1:0]                  in_num,
	input  logic [DW-1:0]                  in_den,
	input  fme_pkg::tag_t                  in_tag,
	output logic                           out_valid,
	output logic [fme_pkg::FRAC_BITS-1:0]  out_quot,
	output fme_pkg::tag_t                  out_tag
);

	localparam int QB = fme_pkg::FRAC_BITS;

	logic [QB-1:0]  v_s;
	logic [DW-1:0]  rem_s  [QB];
	logic [DW-1:0]  den_s  [QB];
	logic [QB-1:0]  quot_s [QB];
	fme_pkg::tag_t  tag_s  [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic          v_in;
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QB-1:0] quot_in;
		fme_pkg::tag_t tag_in;
		logic [DW:0]   trial;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = in_num;
			assign den_in  = in_den;
			assign quot_in = '0;
			assign tag_in  = in_tag;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign den_in  = den_s[k-1];
			assign quot_in = quot_s[k-1];
			assign tag_in  = tag_s[k-1];
		end

		// remainder stays below the divisor, so doubling fits one extra bit
		assign trial = {rem_in, 1'b0} - {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_in;
				tag_s[k] <= tag_in;
				if (!trial[DW]) begin
					rem_s[k]  <= trial[DW-1:0];
					quot_s[k] <= {quot_in[QB-2:0], 1'b1};
				end else begin
					rem_s[k]  <= {rem_in[DW-2:0], 1'b0};
					quot_s[k] <= {quot_in[QB-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[QB-1];
	assign out_quot  = quot_s[QB-1];
	assign out_tag   = tag_s[QB-1];

endmodule
